>>> sv/cfbp_pkg.sv
// Package for the cube face bounds projector: item kinds, faces, widths, the item and
// result types and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
package cfbp_pkg;
	localparam int unsigned MaxVertsDefault = 64;
	localparam int unsigned CoordW = 32;
	localparam int unsigned SumW = 40;
	localparam int unsigned BoundW = 16;
	localparam int unsigned QuotW = 48;

	typedef enum logic [1:0] {
		KIND_VERTEX = 2'd0,
		KIND_CLEAR  = 2'd1,
		KIND_READ   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	localparam logic [2:0] FACE_PX = 3'd0;
	localparam logic [2:0] FACE_NX = 3'd1;
	localparam logic [2:0] FACE_PY = 3'd2;
	localparam logic [2:0] FACE_NY = 3'd3;
	localparam logic [2:0] FACE_PZ = 3'd4;
	localparam logic [2:0] FACE_NZ = 3'd5;

	localparam logic signed [BoundW-1:0] BoundMax = 16'sd32767;
	localparam logic signed [BoundW-1:0] BoundMin = -16'sd32768;

	// One input item and one result item as they cross the channels.
	typedef struct packed {
		kind_t                    kind;
		logic signed [CoordW-1:0] x_coord;
		logic signed [CoordW-1:0] y_coord;
		logic signed [CoordW-1:0] z_coord;
		logic                     last_vertex;
		logic [2:0]               face_select;
	} poly_item_t;

	typedef struct packed {
		logic [2:0]               face;
		logic signed [BoundW-1:0] s_min;
		logic signed [BoundW-1:0] t_min;
		logic signed [BoundW-1:0] s_max;
		logic signed [BoundW-1:0] t_max;
		logic                     overflow;
	} bounds_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_ISSUE,
		ST_DIV_S,
		ST_DIV_T,
		ST_UPDATE,
		ST_OUT
	} state_t;

	// Divider request and answer between the sequencer and the divider.
	typedef struct packed {
		logic                     start;
		logic signed [CoordW:0]   num;
		logic signed [CoordW:0]   den;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [BoundW-1:0] ratio;
	} div_rsp_t;
endpackage

>>> sv/cfbp_if.sv
// Valid/ready channel interface with a generic payload type.
// Depends on nothing beyond the payload type given by the user.
`timescale 1ns / 1ps
interface cfbp_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/cube_face_bounds_projector.sv
// Top level of the cube face bounds projector: vertex store, sums, face choice,
// sequencer and bounds tables. Depends on cfbp_pkg, cfbp_if and cfbp_div.
`timescale 1ns / 1ps
// Usage: items enter on the sink channel "in" (kind, coordinates, last_vertex,
// face_select) and results leave on the source channel "out".
// A vertex that is not last and a clear item are each taken without giving a result;
// a read item gives its registered result in the cycle after it is taken.
// The last vertex starts a walk over the stored vertices: each one passes through a fetch
// state for the registered store read, an issue state, two divisions in the shared
// serial divider (47 quotient bits each, then a hand-over of the answer) and an update
// state, and after the last one the output state registers the polygon's result.
// While the walk runs and while a result waits in the output register the
// input is not ready; a stalled receiver simply holds the block in that state.
// Reset clears the sums, count, overflow flag and all face bounds at once; the
// vertex store needs no clearing as only written entries are read.
module cube_face_bounds_projector
	import cfbp_pkg::*;
#(
	parameter int unsigned MAX_VERTS = MaxVertsDefault
) (
	input logic clk,
	input logic arst_n,
	cfbp_if.sink   in,
	cfbp_if.source out
);
	localparam int unsigned AddrW = $clog2(MAX_VERTS);
	localparam int unsigned CntW  = $clog2(MAX_VERTS + 1);

	logic signed [CoordW-1:0] mem_x [MAX_VERTS];
	logic signed [CoordW-1:0] mem_y [MAX_VERTS];
	logic signed [CoordW-1:0] mem_z [MAX_VERTS];
	logic signed [CoordW-1:0] rd_x_q, rd_y_q, rd_z_q;

	logic signed [SumW-1:0] sum_x_q, sum_y_q, sum_z_q;
	logic [CntW-1:0]  count_q;
	logic [AddrW-1:0] idx_q;
	logic             ovf_q;
	logic [2:0]       face_q;
	logic signed [BoundW-1:0] min_s_q [6];
	logic signed [BoundW-1:0] min_t_q [6];
	logic signed [BoundW-1:0] max_s_q [6];
	logic signed [BoundW-1:0] max_t_q [6];
	logic signed [BoundW-1:0] s_q;

	state_t state_q, state_d;
	div_req_t dreq;
	div_rsp_t drsp;

	logic accept, full, store, walk_last;
	logic signed [SumW-1:0] ax, ay, az;
	logic [2:0] face_pick;
	logic [2:0] rd_face;
	logic signed [CoordW:0] ns, nt, dd;

	assign accept = in.valid && in.ready;
	assign in.ready = (state_q == ST_IDLE) && !out.valid;
	assign full = (count_q == CntW'(MAX_VERTS));
	assign store = accept && (in.data.kind == KIND_VERTEX) && !full;
	assign walk_last = (idx_q == AddrW'(count_q - 1'b1));
	assign rd_face = (in.data.face_select > FACE_NZ) ? FACE_NZ : in.data.face_select;

	// The incoming sum is included so the face can be picked in the accepting cycle.
	always_comb begin
		logic signed [SumW-1:0] tx, ty, tz;
		tx = sum_x_q + (store ? SumW'(in.data.x_coord) : '0);
		ty = sum_y_q + (store ? SumW'(in.data.y_coord) : '0);
		tz = sum_z_q + (store ? SumW'(in.data.z_coord) : '0);
		ax = tx[SumW-1] ? -tx : tx;
		ay = ty[SumW-1] ? -ty : ty;
		az = tz[SumW-1] ? -tz : tz;
		if (ax > ay && ax > az)      face_pick = tx[SumW-1] ? FACE_NX : FACE_PX;
		else if (ay > az && ay > ax) face_pick = ty[SumW-1] ? FACE_NY : FACE_PY;
		else                         face_pick = tz[SumW-1] ? FACE_NZ : FACE_PZ;
	end

	always_comb begin
		logic signed [CoordW:0] x, y, z;
		x = {rd_x_q[CoordW-1], rd_x_q};
		y = {rd_y_q[CoordW-1], rd_y_q};
		z = {rd_z_q[CoordW-1], rd_z_q};
		unique case (face_q)
			FACE_PX: begin ns = -y; nt = z;  dd = x;  end
			FACE_NX: begin ns = y;  nt = z;  dd = -x; end
			FACE_PY: begin ns = x;  nt = z;  dd = y;  end
			FACE_NY: begin ns = -x; nt = z;  dd = -y; end
			FACE_PZ: begin ns = -y; nt = -x; dd = z;  end
			default: begin ns = -y; nt = x;  dd = -z; end
		endcase
	end

	// The fetch cycle lets the store read of the current index land in rd_*_q
	// before the first division is issued.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept && in.data.kind == KIND_VERTEX && in.data.last_vertex)
				state_d = (count_q == '0 && !store) ? ST_OUT : ST_FETCH;
			ST_FETCH:  state_d = ST_ISSUE;
			ST_ISSUE:  state_d = ST_DIV_S;
			ST_DIV_S:  if (drsp.done) state_d = ST_DIV_T;
			ST_DIV_T:  if (drsp.done) state_d = ST_UPDATE;
			ST_UPDATE: state_d = walk_last ? ST_OUT : ST_FETCH;
			ST_OUT:    state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		dreq.start = 1'b0;
		dreq.num = ns;
		dreq.den = dd;
		unique case (state_q)
			ST_ISSUE: dreq.start = 1'b1;
			ST_DIV_S: if (drsp.done) begin
				dreq.start = 1'b1;
				dreq.num = nt;
			end
			default: dreq.start = 1'b0;
		endcase
	end

	cfbp_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_ff @(posedge clk) begin
		if (store) begin
			mem_x[count_q[AddrW-1:0]] <= in.data.x_coord;
			mem_y[count_q[AddrW-1:0]] <= in.data.y_coord;
			mem_z[count_q[AddrW-1:0]] <= in.data.z_coord;
		end
		rd_x_q <= mem_x[idx_q];
		rd_y_q <= mem_y[idx_q];
		rd_z_q <= mem_z[idx_q];
		if (state_q == ST_DIV_S && drsp.done) s_q <= drsp.ratio;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			count_q <= '0;
			idx_q <= '0;
			ovf_q <= 1'b0;
			face_q <= FACE_PX;
			out.valid <= 1'b0;
			out.data <= '0;
			for (int i = 0; i < 6; i++) begin
				min_s_q[i] <= BoundMax;
				min_t_q[i] <= BoundMax;
				max_s_q[i] <= BoundMin;
				max_t_q[i] <= BoundMin;
			end
		end else begin
			state_q <= state_d;
			if (out.valid && out.ready) out.valid <= 1'b0;
			if (accept) begin
				unique case (in.data.kind)
					KIND_VERTEX: begin
						if (store) begin
							sum_x_q <= sum_x_q + SumW'(in.data.x_coord);
							sum_y_q <= sum_y_q + SumW'(in.data.y_coord);
							sum_z_q <= sum_z_q + SumW'(in.data.z_coord);
							count_q <= count_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (in.data.last_vertex) begin
							face_q <= face_pick;
							idx_q <= '0;
						end
					end
					KIND_CLEAR: begin
						for (int i = 0; i < 6; i++) begin
							min_s_q[i] <= BoundMax;
							min_t_q[i] <= BoundMax;
							max_s_q[i] <= BoundMin;
							max_t_q[i] <= BoundMin;
						end
					end
					KIND_READ: begin
						out.valid <= 1'b1;
						out.data.face <= rd_face;
						out.data.s_min <= min_s_q[rd_face];
						out.data.t_min <= min_t_q[rd_face];
						out.data.s_max <= max_s_q[rd_face];
						out.data.t_max <= max_t_q[rd_face];
						out.data.overflow <= ovf_q;
					end
					default: ;
				endcase
			end
			if (state_q == ST_UPDATE) begin
				if (s_q < min_s_q[face_q]) min_s_q[face_q] <= s_q;
				if (s_q > max_s_q[face_q]) max_s_q[face_q] <= s_q;
				if (drsp.ratio < min_t_q[face_q]) min_t_q[face_q] <= drsp.ratio;
				if (drsp.ratio > max_t_q[face_q]) max_t_q[face_q] <= drsp.ratio;
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == ST_OUT) begin
				out.valid <= 1'b1;
				out.data.face <= face_q;
				out.data.s_min <= min_s_q[face_q];
				out.data.t_min <= min_t_q[face_q];
				out.data.s_max <= max_s_q[face_q];
				out.data.t_max <= max_t_q[face_q];
				out.data.overflow <= ovf_q;
				sum_x_q <= '0;
				sum_y_q <= '0;
				sum_z_q <= '0;
				count_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end
endmodule

>>> sv/cfbp_div.sv
// Shared restoring divider, one quotient bit a cycle, giving num*16384/den in Q1.14
// with truncation toward zero and saturation. Depends on cfbp_pkg.
`timescale 1ns / 1ps
module cfbp_div
	import cfbp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int unsigned MagW = CoordW + 15;
	localparam int unsigned CntW = $clog2(QuotW + 1);

	logic [MagW-1:0]  num_mag_q;
	logic [CoordW:0]  den_mag_q;
	logic [MagW:0]    rem_q;
	logic [QuotW-1:0] quo_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic             neg_q;
	logic             zero_q;
	logic [1:0]       zsign_q;
	logic             done_q;

	logic [MagW:0]    rem_sh;
	logic [MagW:0]    rem_sub;
	logic             take;
	logic [CoordW:0]  num_abs;
	logic [CoordW:0]  den_abs;
	logic signed [BoundW-1:0] ratio;

	assign num_abs = req.num[CoordW] ? -req.num : req.num;
	assign den_abs = req.den[CoordW] ? -req.den : req.den;
	assign rem_sh  = {rem_q[MagW-1:0], num_mag_q[MagW-1]};
	assign rem_sub = rem_sh - {{(MagW - CoordW){1'b0}}, den_mag_q};
	assign take    = !rem_sub[MagW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(MagW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_mag_q <= {num_abs[CoordW-1:0], 14'd0, 1'b0} >> 1 | {num_abs, 14'd0};
			den_mag_q <= den_abs;
			rem_q     <= '0;
			quo_q     <= '0;
			neg_q     <= req.num[CoordW] ^ req.den[CoordW];
			zero_q    <= (req.den == '0);
			zsign_q   <= {req.num[CoordW], req.num != '0};
		end else if (busy_q) begin
			rem_q     <= take ? rem_sub : rem_sh;
			quo_q     <= {quo_q[QuotW-2:0], take};
			num_mag_q <= {num_mag_q[MagW-2:0], 1'b0};
		end
	end

	always_comb begin
		if (zero_q) begin
			if (!zsign_q[0])     ratio = '0;
			else if (zsign_q[1]) ratio = BoundMin;
			else                 ratio = BoundMax;
		end else if (neg_q) begin
			ratio = (quo_q > QuotW'(32768)) ? BoundMin : BoundW'(-quo_q);
		end else begin
			ratio = (quo_q > QuotW'(32767)) ? BoundMax : BoundW'(quo_q);
		end
	end

	assign rsp = '{done: done_q, ratio: ratio};
endmodule

>>> sv/cfbp_checker.sv
// Port-level checker for the cube face bounds projector, bound to the top level.
// Depends on cfbp_pkg and cube_face_bounds_projector.
`timescale 1ns / 1ps
module cfbp_checker
	import cfbp_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] out_face,
	input logic signed [BoundW-1:0] out_s_min
);
	// The block never takes an item while a result is still waiting.
	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("item taken while result pending");

	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_face <= FACE_NZ) else $error("face out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_s_min))
		else $error("stalled item changed");

	// Once reset has been seen at an edge, no result is offered at the next one.
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid) else $error("result during reset");
endmodule

bind cube_face_bounds_projector cfbp_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in.valid), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready),
	.out_face(out.data.face), .out_s_min(out.data.s_min)
);

>>> test/cube_face_bounds_projector_test.sv
// Self-checking testbench for cube_face_bounds_projector: directed table then random polygons,
// reads and clears, checked against a predictor. Depends on cfbp_pkg, cfbp_if and the top level.
`timescale 1ns / 1ps
module cube_face_bounds_projector_test;
	import cfbp_pkg::*;

	typedef struct {
		poly_item_t it;
		bit         typed;
		bounds_t    res;
		bit         drain;
	} stim_row_t;

	localparam int Verts = 64;
	localparam int CycleLimit = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	cfbp_if #(.payload_t(poly_item_t)) in_ch (clk);
	cfbp_if #(.payload_t(bounds_t)) out_ch (clk);

	cube_face_bounds_projector #(.MAX_VERTS(Verts)) dut (
		.clk(clk), .arst_n(arst_n), .in(in_ch.sink), .out(out_ch.source)
	);

	always #5 clk = ~clk;

	// Predictor state.
	logic signed [31:0] px[Verts], py[Verts], pz[Verts];
	longint sx, sy, sz;
	int vcount;
	bit ovf_flag;
	logic signed [15:0] mins[6], mint[6], maxs[6], maxt[6];

	stim_row_t stim[$];
	bounds_t bounds_q[$];
	int errors = 0, n_polys = 0, n_reads = 0, n_ovf = 0;
	int cycles = 0;
	int acc_idx = 0;
	bit idle_on = 1'b1, hold_req = 1'b0, hold_done = 1'b0;
	int hold_left = 0;

	function automatic logic signed [15:0] q14(longint num, longint den);
		longint q;
		if (den == 0) begin
			if (num > 0) return BoundMax;
			if (num < 0) return BoundMin;
			return 16'sd0;
		end
		q = (num * 16384) / den;
		if (q > 32767) return BoundMax;
		if (q < -32768) return BoundMin;
		return q[15:0];
	endfunction

	function automatic void reset_bounds();
		for (int i = 0; i < 6; i++) begin
			mins[i] = BoundMax;
			mint[i] = BoundMax;
			maxs[i] = BoundMin;
			maxt[i] = BoundMin;
		end
	endfunction

	function automatic bounds_t face_bounds(int f, bit ovf);
		bounds_t r;
		r.face = f[2:0];
		r.s_min = mins[f];
		r.t_min = mint[f];
		r.s_max = maxs[f];
		r.t_max = maxt[f];
		r.overflow = ovf;
		return r;
	endfunction

	// Advances the predicted state by one item; returns 1 when a result follows.
	function automatic bit project_item(poly_item_t it, output bounds_t r);
		longint ax, ay, az, x, y, z, ns, nt, d;
		logic signed [15:0] s, t;
		int f;
		bit ovf;
		r = '0;
		case (it.kind)
			KIND_VERTEX: begin
				if (vcount < Verts) begin
					px[vcount] = it.x_coord;
					py[vcount] = it.y_coord;
					pz[vcount] = it.z_coord;
					sx += it.x_coord;
					sy += it.y_coord;
					sz += it.z_coord;
					vcount++;
				end else begin
					ovf_flag = 1'b1;
				end
				if (!it.last_vertex) return 1'b0;
				ax = sx < 0 ? -sx : sx;
				ay = sy < 0 ? -sy : sy;
				az = sz < 0 ? -sz : sz;
				if (ax > ay && ax > az) f = sx < 0 ? FACE_NX : FACE_PX;
				else if (ay > az && ay > ax) f = sy < 0 ? FACE_NY : FACE_PY;
				else f = sz < 0 ? FACE_NZ : FACE_PZ;
				for (int i = 0; i < vcount; i++) begin
					x = px[i];
					y = py[i];
					z = pz[i];
					case (f)
						FACE_PX: begin ns = -y; nt = z; d = x; end
						FACE_NX: begin ns = y; nt = z; d = -x; end
						FACE_PY: begin ns = x; nt = z; d = y; end
						FACE_NY: begin ns = -x; nt = z; d = -y; end
						FACE_PZ: begin ns = -y; nt = -x; d = z; end
						default: begin ns = -y; nt = x; d = -z; end
					endcase
					s = q14(ns, d);
					t = q14(nt, d);
					if (s < mins[f]) mins[f] = s;
					if (t < mint[f]) mint[f] = t;
					if (s > maxs[f]) maxs[f] = s;
					if (t > maxt[f]) maxt[f] = t;
				end
				ovf = ovf_flag;
				r = face_bounds(f, ovf);
				vcount = 0;
				sx = 0;
				sy = 0;
				sz = 0;
				ovf_flag = 1'b0;
				return 1'b1;
			end
			KIND_CLEAR: begin
				reset_bounds();
				return 1'b0;
			end
			KIND_READ: begin
				f = it.face_select > 5 ? 5 : it.face_select;
				r = face_bounds(f, ovf_flag);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
	endtask

	task automatic check_bounds(string tag, bounds_t got, bounds_t want);
		if (got.face != want.face) report({tag, " face"}, got.face, want.face);
		if (got.s_min != want.s_min) report({tag, " s_min"}, got.s_min, want.s_min);
		if (got.t_min != want.t_min) report({tag, " t_min"}, got.t_min, want.t_min);
		if (got.s_max != want.s_max) report({tag, " s_max"}, got.s_max, want.s_max);
		if (got.t_max != want.t_max) report({tag, " t_max"}, got.t_max, want.t_max);
		if (got.overflow != want.overflow)
			report({tag, " overflow"}, got.overflow, want.overflow);
	endtask

	function automatic void add(kind_t k, longint x, longint y, longint z, bit last,
			int fs, bit typed = 0, bounds_t res = '0);
		stim_row_t row;
		row.it.kind = k;
		row.it.x_coord = x[31:0];
		row.it.y_coord = y[31:0];
		row.it.z_coord = z[31:0];
		row.it.last_vertex = last;
		row.it.face_select = fs[2:0];
		row.typed = typed;
		row.res = res;
		row.drain = 1'b0;
		stim.push_back(row);
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'd0;
			3, 4: return $urandom;
			default: return 32'($signed($urandom_range(0, 8191)) - 4096);
		endcase
	endfunction

	function automatic void add_random_vertex(bit last);
		add(KIND_VERTEX, $signed(rand_coord()), $signed(rand_coord()), $signed(rand_coord()),
			last, $urandom_range(0, 7));
	endfunction

	function automatic void build_stimulus();
		bounds_t rst, zero;
		int nv;
		rst = '{3'd0, BoundMax, BoundMax, BoundMin, BoundMin, 1'b0};
		zero = '0;
		// Directed table: reset contents, face aliasing, ignored kind, each face, ties,
		// zero divisors, saturation and a clear.
		add(KIND_READ, 0, 0, 0, 0, 0, 1, rst);
		rst.face = FACE_NZ;
		add(KIND_READ, 0, 0, 0, 0, 7, 1, rst);
		add(KIND_READ, 0, 0, 0, 0, 6, 1, rst);
		add(KIND_NONE, -1, -1, -1, 1, 7);
		zero.face = FACE_PX;
		add(KIND_VERTEX, 256, 0, 0, 1, 0, 1, zero);
		zero.face = FACE_PZ;
		add(KIND_VERTEX, 0, 0, 0, 1, 0, 1, zero);
		zero.face = FACE_NZ;
		add(KIND_VERTEX, 0, 0, -256, 1, 0, 1, zero);
		zero.face = FACE_NX;
		add(KIND_VERTEX, -256, 0, 0, 1, 0, 1, zero);
		zero.face = FACE_NY;
		add(KIND_VERTEX, 0, -256, 0, 1, 0, 1, zero);
		add(KIND_VERTEX, 0, 256, 0, 0, 0);
		add(KIND_VERTEX, 100, 300, -50, 1, 0);
		add(KIND_VERTEX, 32'h7fffffff, -32'sh80000000, 0, 1, 0);
		add(KIND_VERTEX, 256, 32'h7fffffff, -32'sh80000000, 0, 0);
		add(KIND_VERTEX, 1, 0, 0, 1, 0);
		add(KIND_VERTEX, 512, 512, 0, 1, 0);
		add(KIND_VERTEX, -32'sh80000000, -32'sh80000000, -32'sh80000000, 1, 0);
		add(KIND_READ, 0, 0, 0, 0, 3);
		add(KIND_READ, 0, 0, 0, 0, 5);
		rst.face = FACE_PZ;
		add(KIND_CLEAR, 0, 0, 0, 0, 0);
		add(KIND_READ, 0, 0, 0, 0, 4, 1, rst);
		stim[$].drain = 1'b1;

		// Random part: mostly well-formed polygons, some long enough to overflow.
		while (stim.size() < 1950) begin
			if ($urandom_range(0, 99) < 3) nv = Verts + $urandom_range(1, 6);
			else if ($urandom_range(0, 99) < 5) nv = $urandom_range(8, 24);
			else nv = $urandom_range(1, 6);
			if ($urandom_range(0, 9) == 0) stim[$].drain = 1'b1;
			for (int i = 0; i < nv; i++) begin
				add_random_vertex(i == nv - 1);
				// Reads may fall inside a polygon in progress.
				if (i != nv - 1 && $urandom_range(0, 39) == 0)
					add(KIND_READ, $urandom, $urandom, $urandom, 1'($urandom),
						$urandom_range(0, 7));
				if (i == Verts + 1)
					add(KIND_READ, 0, 0, 0, 0, $urandom_range(0, 7));
			end
			case ($urandom_range(0, 19))
				0: add(KIND_CLEAR, $urandom, $urandom, $urandom, 1'($urandom),
					$urandom_range(0, 7));
				1: add(KIND_NONE, $urandom, $urandom, $urandom, 1'($urandom),
					$urandom_range(0, 7));
				2, 3, 4: add(KIND_READ, $urandom, $urandom, $urandom, 1'($urandom),
					$urandom_range(0, 7));
				default: ;
			endcase
		end
	endfunction

	// Prediction on acceptance and checking of results.
	always @(posedge clk) begin
		bounds_t r, want;
		bit has;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			has = project_item(in_ch.data, r);
			// Rows with a typed result must agree with the prediction; the typed one is kept.
			if (acc_idx < stim.size() && stim[acc_idx].typed) begin
				if (!has) report($sformatf("typed row %0d result", acc_idx), 0, 1);
				else check_bounds($sformatf("typed row %0d", acc_idx), r, stim[acc_idx].res);
				r = stim[acc_idx].res;
				has = 1'b1;
			end
			if (has) bounds_q.push_back(r);
			acc_idx++;
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			r = out_ch.data;
			if (bounds_q.size() == 0) begin
				report("unexpected result for face", r.face, -1);
			end else begin
				want = bounds_q.pop_front();
				check_bounds("result", r, want);
				if (r.overflow) n_ovf++;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= 400;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !(idle_on && $urandom_range(0, 99) < 30);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("cube_face_bounds_projector_test: FAIL");
			$finish;
		end
	end

	// Sender.
	initial begin
		int sent;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		reset_bounds();
		vcount = 0;
		sx = 0;
		sy = 0;
		sz = 0;
		ovf_flag = 1'b0;
		build_stimulus();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		sent = 0;
		while (sent < stim.size()) begin
			@(posedge clk);
			if (in_ch.valid && !in_ch.ready) continue;
			if (in_ch.valid) begin
				if (stim[sent].it.kind == KIND_READ) n_reads++;
				if (stim[sent].it.kind == KIND_VERTEX && stim[sent].it.last_vertex) n_polys++;
				sent++;
				if (sent == 600) hold_req = 1'b1;
				idle_on = !(sent >= 900 && sent < 1200);
				if (sent == stim.size()) begin
					in_ch.valid <= 1'b0;
					break;
				end
				if (stim[sent - 1].drain) begin
					in_ch.valid <= 1'b0;
					// Let the predictor see the last item before waiting on the queue.
					@(negedge clk);
					while (bounds_q.size() != 0) @(posedge clk);
					@(posedge clk);
				end
			end
			if (idle_on && $urandom_range(0, 99) < 30) begin
				in_ch.valid <= 1'b0;
			end else begin
				in_ch.valid <= 1'b1;
				in_ch.data <= stim[sent].it;
			end
		end
		@(negedge clk);
		while (bounds_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d items: %0d polygons, %0d reads, %0d overflowed results",
			stim.size(), n_polys, n_reads, n_ovf);
		if (errors == 0) begin
			$display("cube_face_bounds_projector_test: PASS");
		end else begin
			$display("%0d mismatches", errors);
			$display("cube_face_bounds_projector_test: FAIL");
		end
		$finish;
	end
endmodule

>>> files.f
sv/cfbp_pkg.sv
sv/cfbp_if.sv
sv/cfbp_div.sv
sv/cube_face_bounds_projector.sv
sv/cfbp_checker.sv
test/cube_face_bounds_projector_test.sv
